/* rtl/core/ts_packet_aes_ecb_descrambler_macros.svh */
// Assertion macros for the transport stream descrambler checker
`ifndef TS_PACKET_AES_ECB_DESCRAMBLER_MACROS_SVH
`define TS_PACKET_AES_ECB_DESCRAMBLER_MACROS_SVH
// property that must hold whenever reset is released
`define TSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked each clock
`define TSD_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

/* rtl/core/tsd_pkg.sv */
// Package: payload types, constants, S-box functions and GF helpers
package tsd_pkg;

    localparam int PacketBytes = 188;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_packet_start;
        logic       run_last;
        logic       bad_offset;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_CLEAR,
        ST_KEYEXP,
        ST_ROUND,
        ST_DRAIN
    } tsd_state_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_index_t;

    // control between sequencer and AES unit
    typedef struct packed {
        logic start;
        logic keyexp;
    } aes_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] r;
        unique case (v)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // GF helpers; inverse S-box by search over the forward S-box table
    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ x;
            x = xt(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int k = 0; k < 256; k++)
        begin
            if (sbox(k[7:0]) == v)
                r = k[7:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/tsd_aes_unit.sv */
// Shared AES-128 decryption round unit with iterative key expansion
module tsd_aes_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  tsd_pkg::aes_ctrl_t  ctrl,
    input  logic [127:0]        key,
    input  logic [127:0]        block_in,
    output logic [127:0]        block_out,
    output logic                done
);

    // round key store, one 128-bit word per round
    logic [127:0] rk_mem [0:10];
    logic [127:0] cur_key_reg, cur_key_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         kbusy_reg, kbusy_next;
    logic         dbusy_reg, dbusy_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_rd;
    logic         done_reg, done_next;

    logic [127:0] nk;
    logic [31:0]  tw;
    logic [127:0] isr;
    logic [127:0] ark;
    logic [127:0] imc;

    // next round key word chain
    always_comb
    begin
        tw = {tsd_pkg::sbox(cur_key_reg[23:16]) ^ rcon_reg,
              tsd_pkg::sbox(cur_key_reg[15:8]),
              tsd_pkg::sbox(cur_key_reg[7:0]),
              tsd_pkg::sbox(cur_key_reg[31:24])};
        nk[127:96] = cur_key_reg[127:96] ^ tw;
        nk[95:64]  = cur_key_reg[95:64] ^ nk[127:96];
        nk[63:32]  = cur_key_reg[63:32] ^ nk[95:64];
        nk[31:0]   = cur_key_reg[31:0] ^ nk[63:32];
    end

    // inverse shift rows, inverse sub bytes, add key, inverse mix columns
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                isr[127 - 8*(r + 4*c) -: 8] =
                    tsd_pkg::inv_sbox(st_reg[127 - 8*(r + 4*((c - r) & 3)) -: 8]);
            end
        end
        ark = isr ^ rk_rd;
        for (int c = 0; c < 4; c++)
        begin
            imc[127 - 32*c -: 8] = tsd_pkg::gmul(ark[127-32*c -: 8], 8'd14)
                ^ tsd_pkg::gmul(ark[119-32*c -: 8], 8'd11)
                ^ tsd_pkg::gmul(ark[111-32*c -: 8], 8'd13)
                ^ tsd_pkg::gmul(ark[103-32*c -: 8], 8'd9);
            imc[119 - 32*c -: 8] = tsd_pkg::gmul(ark[127-32*c -: 8], 8'd9)
                ^ tsd_pkg::gmul(ark[119-32*c -: 8], 8'd14)
                ^ tsd_pkg::gmul(ark[111-32*c -: 8], 8'd11)
                ^ tsd_pkg::gmul(ark[103-32*c -: 8], 8'd13);
            imc[111 - 32*c -: 8] = tsd_pkg::gmul(ark[127-32*c -: 8], 8'd13)
                ^ tsd_pkg::gmul(ark[119-32*c -: 8], 8'd9)
                ^ tsd_pkg::gmul(ark[111-32*c -: 8], 8'd14)
                ^ tsd_pkg::gmul(ark[103-32*c -: 8], 8'd11);
            imc[103 - 32*c -: 8] = tsd_pkg::gmul(ark[127-32*c -: 8], 8'd11)
                ^ tsd_pkg::gmul(ark[119-32*c -: 8], 8'd13)
                ^ tsd_pkg::gmul(ark[111-32*c -: 8], 8'd9)
                ^ tsd_pkg::gmul(ark[103-32*c -: 8], 8'd14);
        end
    end

    // sequencing of key expansion and rounds
    always_comb
    begin
        cur_key_next = cur_key_reg;
        rcon_next    = rcon_reg;
        cnt_next     = cnt_reg;
        kbusy_next   = kbusy_reg;
        dbusy_next   = dbusy_reg;
        st_next      = st_reg;
        done_next    = 1'b0;
        if (ctrl.keyexp)
        begin
            cur_key_next = key;
            rcon_next    = 8'h01;
            cnt_next     = 4'd1;
            kbusy_next   = 1'b1;
        end
        else if (kbusy_reg)
        begin
            cur_key_next = nk;
            rcon_next    = tsd_pkg::xt(rcon_reg);
            if (cnt_reg == 4'd10)
            begin
                kbusy_next = 1'b0;
                done_next  = 1'b1;
            end
            cnt_next = cnt_reg + 4'd1;
        end
        else if (ctrl.start)
        begin
            st_next    = block_in;
            cnt_next   = 4'd10;
            dbusy_next = 1'b1;
        end
        else if (dbusy_reg)
        begin
            // round key 10 addressed at start: whitening first
            if (cnt_reg == 4'd10 && !done_reg)
                st_next = st_reg ^ rk_rd;
            else if (cnt_reg == 4'd0)
            begin
                st_next    = ark;
                dbusy_next = 1'b0;
                done_next  = 1'b1;
            end
            else
                st_next = imc;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd10 && !done_reg)
                cnt_next = 4'd9;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcon_reg  <= 8'h01;
            cnt_reg   <= 4'd0;
            kbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rcon_reg  <= rcon_next;
            cnt_reg   <= cnt_next;
            kbusy_reg <= kbusy_next;
            dbusy_reg <= dbusy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_key_reg <= cur_key_next;
        st_reg      <= st_next;
    end

    // round key memory: written during expansion, read by round count
    always_ff @(posedge clk)
    begin
        if (ctrl.keyexp)
            rk_mem[0] <= key;
        else if (kbusy_reg)
            rk_mem[cnt_reg] <= nk;
    end

    always_comb
    begin
        rk_rd = rk_mem[cnt_reg];
    end

    assign block_out = st_reg;
    assign done      = done_reg;

endmodule

/* rtl/core/tsd_parser.sv */
// Packet header parser and byte classifier
module tsd_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       packet_start,
    output logic [7:0] mod_byte,
    output logic       first_byte,
    output logic       in_block,
    output logic       overrun
);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] off_reg, off_next;
    logic [1:0] mode_reg, mode_next;
    logic       ovr_reg, ovr_next;
    logic       afp_reg, afp_next;
    logic [7:0] p;
    logic [8:0] off9;
    logic [7:0] endp;
    logic [7:0] rem;

    always_comb
    begin
        p        = packet_start ? 8'd0 : pos_reg;
        pos_next = pos_reg;
        off_next = off_reg;
        mode_next = mode_reg;
        ovr_next = ovr_reg;
        afp_next = afp_reg;
        mod_byte = data_byte;
        in_block = 1'b0;
        off9     = 9'd5 + {1'b0, data_byte};
        if (p == 8'd0)
        begin
            mode_next = 2'd0;
            off_next  = 8'd4;
            ovr_next  = 1'b0;
            afp_next  = 1'b0;
        end
        if (p < 8'(tsd_pkg::PacketBytes))
        begin
            if (p == 8'd3)
            begin
                mode_next = data_byte[7:6];
                afp_next  = data_byte[7] && data_byte[5];
                if (data_byte[7:6] != 2'd0)
                    mod_byte = data_byte & 8'h3f;
            end
            else if (p == 8'd4 && afp_next)
            begin
                if (off9 > 9'(tsd_pkg::PacketBytes))
                begin
                    off_next = 8'(tsd_pkg::PacketBytes);
                    ovr_next = 1'b1;
                end
                else
                    off_next = off9[7:0];
                afp_next = 1'b0;
            end
            rem  = 8'(tsd_pkg::PacketBytes) - off_next;
            endp = off_next + {rem[7:4], 4'd0};
            in_block = (mode_next != 2'd0) && (p >= 8'd4) && !afp_next
                       && (p >= off_next) && (p < endp);
            pos_next = p + 8'd1;
        end
        else
        begin
            rem  = 8'd0;
            endp = 8'd0;
        end
    end

    assign first_byte = (p == 8'd0);
    assign overrun    = ovr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 8'd0;
            off_reg  <= 8'd4;
            mode_reg <= 2'd0;
            ovr_reg  <= 1'b0;
            afp_reg  <= 1'b0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            off_reg  <= off_next;
            mode_reg <= mode_next;
            ovr_reg  <= ovr_next;
            afp_reg  <= afp_next;
        end
    end

endmodule

/* rtl/core/ts_packet_aes_ecb_descrambler.sv */
// Top level: transport stream AES-128 ECB descrambler
// Usage:
//  - in / in_valid / in_ready: one stream byte per transaction, packet_start
//    on byte 0 of each packet.
//  - out / out_valid / out_ready: results, run_last on the last result that
//    one input transaction causes.
//  - APB port: key_high at 0x0, key_low at 0x8 (64-bit data). Write only
//    while idle.
// Byte handling:
//  - A clear byte gives its result in the cycle after acceptance, plus the
//    output handshake; the next byte is taken after its result is taken.
//  - A byte held for a block gives no result; the next byte can be taken in
//    the following cycle.
//  - A byte that completes a 16-byte block runs key expansion and then ten
//    inverse rounds plus whitening on the shared round unit, then drains
//    16 results, one per accepted output.
//  - A packet_start that cuts a partly filled block first flushes the held
//    bytes in clear, one per output transaction.
// Reset clears all control state; the key resets to zero.
// A stalled receiver holds the current result; no input is taken meanwhile.
module ts_packet_aes_ecb_descrambler
(
    input  logic                clk,
    input  logic                rst_n,
    input  tsd_pkg::in_item_t   in,
    input  logic                in_valid,
    output logic                in_ready,
    output tsd_pkg::out_item_t  out,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    tsd_pkg::tsd_state_t state_reg, state_next;
    logic [63:0] key_high_reg, key_low_reg;
    logic [7:0]  buf_reg [0:15];
    logic [4:0]  fill_reg, fill_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  hold_byte_reg;
    logic        hold_first_reg;
    logic        hold_ovr_reg;
    logic        ovr_now_reg;
    logic        flush_ovr_reg;
    logic        step;
    logic [7:0]  mod_byte;
    logic        first_byte;
    logic        in_blk;
    logic        overrun;
    logic        wr;
    logic [127:0] buf_flat;
    logic [127:0] aes_out;
    logic        aes_done;
    tsd_pkg::aes_ctrl_t actrl;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == tsd_pkg::REG_KEY_LOW) ? key_low_reg : key_high_reg;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
        end
        else if (wr && paddr[2:0] == 3'd0 && paddr[3] == tsd_pkg::REG_KEY_HIGH)
            key_high_reg <= pwdata;
        else if (wr && paddr[2:0] == 3'd0 && paddr[3] == tsd_pkg::REG_KEY_LOW)
            key_low_reg <= pwdata;
    end

    assign in_ready = (state_reg == tsd_pkg::ST_IDLE) && !out_valid;
    assign step = in_valid && in_ready;

    tsd_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (in.data_byte),
        .packet_start (in.packet_start),
        .mod_byte     (mod_byte),
        .first_byte   (first_byte),
        .in_block     (in_blk),
        .overrun      (overrun)
    );

    always_comb
    begin
        for (int k = 0; k < 16; k++)
            buf_flat[127 - 8*k -: 8] = buf_reg[k];
    end

    // the buffer stays still while the round unit runs
    tsd_aes_unit u_aes
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (actrl),
        .key       ({key_high_reg, key_low_reg}),
        .block_in  (buf_flat),
        .block_out (aes_out),
        .done      (aes_done)
    );

    // block buffer write
    always_ff @(posedge clk)
    begin
        if (step && in_blk)
            buf_reg[fill_next[3:0] - 4'd1] <= mod_byte;
        if (step)
        begin
            hold_byte_reg  <= mod_byte;
            hold_first_reg <= first_byte;
            hold_ovr_reg   <= overrun;
            flush_ovr_reg  <= ovr_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovr_now_reg <= 1'b0;
        else if (step)
            ovr_now_reg <= overrun;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        actrl.start     = 1'b0;
        actrl.keyexp    = 1'b0;
        out_valid       = 1'b0;
        out             = '0;
        unique case (state_reg)
            tsd_pkg::ST_IDLE:
            begin
                if (step)
                begin
                    idx_next = 4'd0;
                    if (in.packet_start && fill_reg != 5'd0)
                        state_next = tsd_pkg::ST_FLUSH;
                    else if (in_blk)
                    begin
                        // block byte: held without a result until the block is whole
                        fill_next = {1'b0, fill_reg[3:0]} + 5'd1;
                        if (fill_next == 5'd16)
                        begin
                            state_next   = tsd_pkg::ST_KEYEXP;
                            actrl.keyexp = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = tsd_pkg::ST_CLEAR;
                        if (first_byte)
                            fill_next = 5'd0;
                    end
                end
            end
            tsd_pkg::ST_FLUSH:
            begin
                out_valid = 1'b1;
                out.out_byte = buf_reg[idx_reg];
                out.bad_offset = flush_ovr_reg;
                if (out_ready)
                begin
                    idx_next = idx_reg + 4'd1;
                    if ({1'b0, idx_reg} + 5'd1 == fill_reg)
                    begin
                        fill_next  = 5'd0;
                        state_next = tsd_pkg::ST_CLEAR;
                    end
                end
            end
            tsd_pkg::ST_CLEAR:
            begin
                out_valid = 1'b1;
                out.out_byte = hold_byte_reg;
                out.out_packet_start = hold_first_reg;
                out.run_last = 1'b1;
                out.bad_offset = hold_ovr_reg;
                if (out_ready)
                    state_next = tsd_pkg::ST_IDLE;
            end
            tsd_pkg::ST_KEYEXP:
            begin
                if (aes_done)
                begin
                    actrl.start = 1'b1;
                    state_next  = tsd_pkg::ST_ROUND;
                end
            end
            tsd_pkg::ST_ROUND:
            begin
                if (aes_done)
                begin
                    state_next = tsd_pkg::ST_DRAIN;
                    idx_next   = 4'd0;
                end
            end
            tsd_pkg::ST_DRAIN:
            begin
                out_valid = 1'b1;
                out.out_byte = aes_out[127 - 8*idx_reg -: 8];
                out.run_last = (idx_reg == 4'd15);
                out.bad_offset = hold_ovr_reg;
                if (out_ready)
                begin
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg == 4'd15)
                    begin
                        state_next = tsd_pkg::ST_IDLE;
                        fill_next  = 5'd0;
                    end
                end
            end
            default:
                state_next = tsd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tsd_pkg::ST_IDLE;
            fill_reg       <= 5'd0;
            idx_reg        <= 4'd0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
        end
    end

endmodule

/* rtl/core/tsd_checker.sv */
// Port checker for the descrambler, bound to the top level
`include "ts_packet_aes_ecb_descrambler_macros.svh"
module tsd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input tsd_pkg::out_item_t out,
    input logic               out_valid,
    input logic               out_ready,
    input logic               pready
);
    `TSD_ASSERT(a_pready_high, pready, "pready low")
    `TSD_IMPLY(a_no_overlap, in_ready, !out_valid, "input ready while result pending")
    `TSD_IMPLY(a_out_hold, out_valid && !out_ready, ##1 out_valid && $stable(out),
               "result changed under stall")
    `TSD_IMPLY(a_last_idle, out_valid && out_ready && out.run_last, ##1 !out_valid,
               "result straight after the last of a run")
endmodule

bind ts_packet_aes_ecb_descrambler tsd_checker u_tsd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out       (out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pready    (pready)
);
